// ===== hw/rtl/u16u8_pkg.sv =====
// ----------------------------------------------------------------------------
// u16u8_pkg
// Shared types, constants and UTF-8 length and byte functions of the UTF-16 to UTF-8
// transcoder.
// ----------------------------------------------------------------------------
package u16u8_pkg;

	localparam int unsigned UnitW  = 16;
	localparam int unsigned CpW    = 21;
	localparam int unsigned HighW  = 10;

	// queue between front and back; depth must be a power of two
	localparam int unsigned QDepth = 2;
	localparam int unsigned QAw    = $clog2(QDepth);

	localparam logic [UnitW-1:0] HighFirst = 16'hd800;
	localparam logic [UnitW-1:0] HighLast  = 16'hdbff;
	localparam logic [UnitW-1:0] LowFirst  = 16'hdc00;
	localparam logic [UnitW-1:0] LowLast   = 16'hdfff;
	localparam logic [CpW-1:0]   SuppBase  = 21'h10000;
	localparam logic [CpW-1:0]   ReplChar  = 21'h00fffd;

	// byte count minus one of a UTF-8 sequence
	typedef enum logic [1:0] {
		LEN_1 = 2'd0,
		LEN_2 = 2'd1,
		LEN_3 = 2'd2,
		LEN_4 = 2'd3
	} len_t;

	// one unit of work for the serializer: an optional U+FFFD ahead of
	// an optional main character
	typedef struct packed {
		logic           repl;
		logic           has_main;
		logic [CpW-1:0] cp;
		logic           bad;
	} job_t;

	typedef struct packed {
		logic push;
		job_t job;
	} push_t;

	function automatic len_t utf8_len(logic [CpW-1:0] cp);
		len_t l;
		if (cp < 21'h80) begin
			l = LEN_1;
		end else if (cp < 21'h800) begin
			l = LEN_2;
		end else if (cp < 21'h10000) begin
			l = LEN_3;
		end else begin
			l = LEN_4;
		end
		return l;
	endfunction

	function automatic logic [7:0] utf8_byte(logic [CpW-1:0] cp, len_t len,
			logic [1:0] idx);
		logic [7:0] b;
		b = 8'h00;
		case (len)
			LEN_1: b = {1'b0, cp[6:0]};
			LEN_2: begin
				case (idx)
					2'd0:    b = {3'b110, cp[10:6]};
					default: b = {2'b10, cp[5:0]};
				endcase
			end
			LEN_3: begin
				case (idx)
					2'd0:    b = {4'b1110, cp[15:12]};
					2'd1:    b = {2'b10, cp[11:6]};
					default: b = {2'b10, cp[5:0]};
				endcase
			end
			LEN_4: begin
				case (idx)
					2'd0:    b = {5'b11110, cp[20:18]};
					2'd1:    b = {2'b10, cp[17:12]};
					2'd2:    b = {2'b10, cp[11:6]};
					default: b = {2'b10, cp[5:0]};
				endcase
			end
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

// ===== hw/rtl/u16u8_if.sv =====
// ----------------------------------------------------------------------------
// u16u8 channel interfaces
// Valid/ready channels for code units in and UTF-8 bytes out.
// ----------------------------------------------------------------------------
interface u16u8_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] code_unit;
	logic        end_of_input;

	modport source (output valid, output code_unit, output end_of_input, input ready);
	modport sink   (input valid, input code_unit, input end_of_input, output ready);
endinterface

interface u16u8_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last_of_run;
	logic       malformed;

	modport source (output valid, output out_byte, output last_of_run,
		output malformed, input ready);
	modport sink   (input valid, input out_byte, input last_of_run,
		input malformed, output ready);
endinterface

// ===== hw/rtl/u16u8_front.sv =====
// ----------------------------------------------------------------------------
// u16u8_front
// Accepts code units, applies byte swap, pairs surrogates and turns each
// unit into a job for the serializer, except a high surrogate that it holds.
// ----------------------------------------------------------------------------
module u16u8_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic                 cfg_wdata,
	u16u8_in_if.sink             in_ch,
	input  logic                 q_full,
	output u16u8_pkg::push_t     push
);
	import u16u8_pkg::*;

	logic             swap_q;
	logic             pend_valid_q;
	logic [HighW-1:0] pend_hi_q;

	logic [UnitW-1:0] u;
	logic             is_high;
	logic             is_low;
	logic             eoi;
	logic             acc;

	assign in_ch.ready = !q_full;
	assign acc         = in_ch.valid && in_ch.ready;
	assign eoi         = in_ch.end_of_input;
	assign u           = swap_q ? {in_ch.code_unit[7:0], in_ch.code_unit[15:8]}
	                            : in_ch.code_unit;
	assign is_high     = (u >= HighFirst) && (u <= HighLast);
	assign is_low      = (u >= LowFirst) && (u <= LowLast);

	always_comb begin
		push.job.repl     = 1'b0;
		push.job.has_main = 1'b0;
		push.job.cp       = {{(CpW-UnitW){1'b0}}, u};
		push.job.bad      = 1'b0;
		if (pend_valid_q && is_low) begin
			push.job.has_main = 1'b1;
			push.job.cp       = {1'b0, pend_hi_q, u[HighW-1:0]} + SuppBase;
		end else begin
			// broken pair: replacement ahead of the unit itself
			push.job.repl = pend_valid_q;
			if (is_high) begin
				push.job.has_main = eoi;
				push.job.cp       = ReplChar;
				push.job.bad      = 1'b1;
			end else begin
				push.job.has_main = 1'b1;
			end
		end
		push.push = acc && (push.job.repl || push.job.has_main);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			swap_q       <= 1'b0;
			pend_valid_q <= 1'b0;
			pend_hi_q    <= '0;
		end else begin
			if (cfg_we) begin
				swap_q <= cfg_wdata;
			end
			if (acc) begin
				if (is_high && !eoi && !(pend_valid_q && is_low)) begin
					pend_valid_q <= 1'b1;
					pend_hi_q    <= u[HighW-1:0];
				end else begin
					pend_valid_q <= 1'b0;
					pend_hi_q    <= '0;
				end
			end
		end
	end

endmodule

// ===== hw/rtl/u16u8_queue.sv =====
// ----------------------------------------------------------------------------
// u16u8_queue
// Short job queue that decouples the classifier from the byte serializer.
// ----------------------------------------------------------------------------
module u16u8_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  u16u8_pkg::push_t     push,
	input  logic                 pop,
	output logic                 full,
	output logic                 empty,
	output u16u8_pkg::job_t      head
);
	import u16u8_pkg::*;

	job_t           mem_q [QDepth];
	logic [QAw-1:0] wr_ptr_q;
	logic [QAw-1:0] rd_ptr_q;
	logic [QAw:0]   count_q;

	assign full  = (count_q == (QAw+1)'(QDepth));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push.push) begin
			mem_q[wr_ptr_q] <= push.job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push.push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== hw/rtl/u16u8_back.sv =====
// ----------------------------------------------------------------------------
// u16u8_back
// Serializes queued jobs into UTF-8 bytes, one byte per cycle while the
// receiver is ready, through a registered output stage.
// ----------------------------------------------------------------------------
module u16u8_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_empty,
	input  u16u8_pkg::job_t      head,
	output logic                 pop,
	u16u8_out_if.source          out_ch
);
	import u16u8_pkg::*;

	logic           busy_q;
	logic [CpW-1:0] cp_q;
	logic           bad_q;
	logic [1:0]     idx_q;
	logic           second_q;
	logic [CpW-1:0] second_cp_q;
	logic           second_bad_q;

	logic           out_valid_q;
	logic [7:0]     out_byte_q;
	logic           out_last_q;
	logic           out_bad_q;

	logic           step;
	logic           emit;
	logic [CpW-1:0] e_cp;
	logic           e_bad;
	logic [1:0]     e_idx;
	logic           e_second;
	logic [CpW-1:0] e_second_cp;
	logic           e_second_bad;
	len_t           e_len;
	logic           e_end;

	assign step = !out_valid_q || out_ch.ready;
	assign emit = step && (busy_q || !q_empty);
	assign pop  = step && !busy_q && !q_empty;

	// current character: the one in flight, or straight from the queue head
	always_comb begin
		if (busy_q) begin
			e_cp         = cp_q;
			e_bad        = bad_q;
			e_idx        = idx_q;
			e_second     = second_q;
			e_second_cp  = second_cp_q;
			e_second_bad = second_bad_q;
		end else if (head.repl) begin
			e_cp         = ReplChar;
			e_bad        = 1'b1;
			e_idx        = 2'd0;
			e_second     = head.has_main;
			e_second_cp  = head.cp;
			e_second_bad = head.bad;
		end else begin
			e_cp         = head.cp;
			e_bad        = head.bad;
			e_idx        = 2'd0;
			e_second     = 1'b0;
			e_second_cp  = head.cp;
			e_second_bad = head.bad;
		end
		e_len = utf8_len(e_cp);
		e_end = (e_idx == 2'(e_len));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (step) begin
				out_valid_q <= emit;
			end
			if (emit) begin
				busy_q <= !e_end || e_second;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= utf8_byte(e_cp, e_len, e_idx);
			out_last_q <= e_end && !e_second;
			out_bad_q  <= e_bad;
			if (!e_end) begin
				cp_q         <= e_cp;
				bad_q        <= e_bad;
				idx_q        <= e_idx + 2'd1;
				second_q     <= e_second;
				second_cp_q  <= e_second_cp;
				second_bad_q <= e_second_bad;
			end else begin
				// advance to the character behind the replacement
				cp_q         <= e_second_cp;
				bad_q        <= e_second_bad;
				idx_q        <= 2'd0;
				second_q     <= 1'b0;
				second_cp_q  <= e_second_cp;
				second_bad_q <= e_second_bad;
			end
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.out_byte    = out_byte_q;
	assign out_ch.last_of_run = out_last_q;
	assign out_ch.malformed   = out_bad_q;

endmodule

// ===== hw/rtl/utf16_to_utf8_transcoder_top.sv =====
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder_top
// UTF-16 code units in, UTF-8 bytes out, with surrogate pairing and repair.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  (valid/ready): one 16-bit code unit per item; end_of_input on the
//          final unit of a string turns a high surrogate there into U+FFFD.
//   out_ch (valid/ready): one UTF-8 byte per item; last_of_run marks the final
//          byte caused by one input unit, malformed marks U+FFFD repair bytes.
//   cfg_we/cfg_wdata: byte-swap bit for reversed byte order; write while idle.
// Timing:
//   The first byte of a unit passes the job queue and the output register.
//   The serializer emits one byte per cycle while the receiver is ready; a
//   unit produces one to six bytes (zero for a held high surrogate), and
//   typical text one to three per unit. A two-entry job queue lets the input
//   side accept one unit per cycle while the output drains, until it fills.
// Reset clears the swap bit, any held surrogate, the queue and the output
// register. When the receiver stalls, the output byte holds, the queue fills
// and then in_ch.ready drops until room frees up.
// ----------------------------------------------------------------------------
module utf16_to_utf8_transcoder_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic         cfg_wdata,
	u16u8_in_if.sink     in_ch,
	u16u8_out_if.source  out_ch
);
	import u16u8_pkg::*;

	push_t push;
	job_t  head;
	logic  q_full;
	logic  q_empty;
	logic  pop;

	u16u8_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.q_full    (q_full),
		.push      (push)
	);

	u16u8_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.full   (q_full),
		.empty  (q_empty),
		.head   (head)
	);

	u16u8_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.head    (head),
		.pop     (pop),
		.out_ch  (out_ch)
	);

endmodule

// ===== tb/tb_utf16_to_utf8_transcoder_top.sv =====
// ----------------------------------------------------------------------------
// tb_utf16_to_utf8_transcoder_top
// Drives UTF-16 code units into the transcoder in random bursts, predicts the
// UTF-8 bytes of every accepted unit, and checks each output byte in order
// against the prediction, under both byte orders.
// ----------------------------------------------------------------------------
module tb_utf16_to_utf8_transcoder_top;
	timeunit 1ns;
	timeprecision 1ps;

	import u16u8_pkg::HighFirst;
	import u16u8_pkg::HighLast;
	import u16u8_pkg::LowFirst;
	import u16u8_pkg::LowLast;
	import u16u8_pkg::SuppBase;
	import u16u8_pkg::ReplChar;

	typedef struct packed {
		logic [15:0] unit;
		logic        eoi;
	} unit_item_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       bad;
	} utf8_byte_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	u16u8_in_if  in_ch();
	u16u8_out_if out_ch();

	utf16_to_utf8_transcoder_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	unit_item_t units_to_send[$];
	utf8_byte_t expected_bytes[$];
	utf8_byte_t unit_bytes[$];
	int         units_outstanding = 0;
	int         mismatches = 0;

	// predictor copy of the swap bit and the held high surrogate
	logic       swap_cfg = 1'b0;
	logic [9:0] held_bits = '0;
	logic       held_valid = 1'b0;

	logic       in_taken = 1'b0;
	int         burst_left = 0;
	int         gap_left = 0;
	unit_item_t next_unit;
	logic       next_valid;
	int         rx_mode = 0;
	int         rx_mode_left = 0;
	int         stall_left = 0;
	logic       next_ready;
	utf8_byte_t want;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("tb_utf16_to_utf8_transcoder_top failed");
		$finish;
	end

	task automatic report_mismatch(input string what);
		$display("%0t: mismatch: %s", $time, what);
		mismatches++;
	endtask

	function automatic void put_code_point(input logic [20:0] cp, input logic bad);
		if (cp < 21'h80) begin
			unit_bytes.push_back('{cp[7:0], 1'b0, bad});
		end else if (cp < 21'h800) begin
			unit_bytes.push_back('{{3'b110, cp[10:6]}, 1'b0, bad});
			unit_bytes.push_back('{{2'b10, cp[5:0]}, 1'b0, bad});
		end else if (cp < 21'h10000) begin
			unit_bytes.push_back('{{4'b1110, cp[15:12]}, 1'b0, bad});
			unit_bytes.push_back('{{2'b10, cp[11:6]}, 1'b0, bad});
			unit_bytes.push_back('{{2'b10, cp[5:0]}, 1'b0, bad});
		end else begin
			unit_bytes.push_back('{{5'b11110, cp[20:18]}, 1'b0, bad});
			unit_bytes.push_back('{{2'b10, cp[17:12]}, 1'b0, bad});
			unit_bytes.push_back('{{2'b10, cp[11:6]}, 1'b0, bad});
			unit_bytes.push_back('{{2'b10, cp[5:0]}, 1'b0, bad});
		end
	endfunction

	// work out the bytes one accepted unit causes and queue them
	function automatic void predict_utf8(input logic [15:0] raw, input logic eoi);
		logic [15:0] u;
		logic        is_high;
		logic        is_low;
		logic        paired;
		u = swap_cfg ? {raw[7:0], raw[15:8]} : raw;
		is_high = (u >= HighFirst) && (u <= HighLast);
		is_low = (u >= LowFirst) && (u <= LowLast);
		paired = 1'b0;
		unit_bytes.delete();
		if (held_valid) begin
			held_valid = 1'b0;
			if (is_low) begin
				put_code_point(SuppBase + {1'b0, held_bits, 10'b0} + {11'b0, u[9:0]}, 1'b0);
				paired = 1'b1;
			end else begin
				put_code_point(ReplChar, 1'b1);
			end
			held_bits = '0;
		end
		if (!paired) begin
			if (is_high) begin
				if (eoi) begin
					put_code_point(ReplChar, 1'b1);
				end else begin
					held_bits = u[9:0];
					held_valid = 1'b1;
				end
			end else begin
				put_code_point({5'b0, u}, 1'b0);
			end
		end
		if (unit_bytes.size() != 0)
			unit_bytes[unit_bytes.size() - 1].last = 1'b1;
		foreach (unit_bytes[i])
			expected_bytes.push_back(unit_bytes[i]);
	endfunction

	// unit driver: bursts of random length with random gaps
	always @(negedge clk) begin
		next_valid = in_ch.valid;
		if (in_ch.valid && !in_taken) begin
			// hold the item until it is taken
		end else if (gap_left != 0) begin
			gap_left--;
			next_valid = 1'b0;
		end else if (units_to_send.size() != 0) begin
			next_unit = units_to_send.pop_front();
			next_valid = 1'b1;
			in_ch.code_unit <= next_unit.unit;
			in_ch.end_of_input <= next_unit.eoi;
			if (burst_left <= 1) begin
				burst_left = $urandom_range(1, 24);
				gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			end else begin
				burst_left--;
			end
		end else begin
			next_valid = 1'b0;
		end
		in_ch.valid <= next_valid;
	end

	// byte receiver: modes of always ready, coin flips and long stalls
	always @(negedge clk) begin
		if (rx_mode_left == 0) begin
			rx_mode = $urandom_range(0, 2);
			rx_mode_left = $urandom_range(50, 300);
		end else begin
			rx_mode_left--;
		end
		if (stall_left != 0) begin
			stall_left--;
			next_ready = 1'b0;
		end else begin
			case (rx_mode)
				0: next_ready = 1'b1;
				1: next_ready = 1'($urandom_range(0, 1));
				default: begin
					next_ready = 1'b1;
					if ($urandom_range(0, 7) == 0)
						stall_left = $urandom_range(1, 16);
				end
			endcase
		end
		out_ch.ready <= next_ready;
	end

	// monitor: predict on every accepted unit, check every accepted byte
	always @(posedge clk) begin
		in_taken <= (in_ch.valid === 1'b1) && (in_ch.ready === 1'b1);
		if (arst_n && in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
			predict_utf8(in_ch.code_unit, in_ch.end_of_input);
			units_outstanding--;
		end
		if (arst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			if (expected_bytes.size() == 0) begin
				report_mismatch($sformatf("unexpected byte %02h", out_ch.out_byte));
			end else begin
				want = expected_bytes.pop_front();
				if (out_ch.out_byte !== want.data)
					report_mismatch($sformatf("out_byte %02h, expected %02h",
						out_ch.out_byte, want.data));
				if (out_ch.last_of_run !== want.last)
					report_mismatch($sformatf("last_of_run %b, expected %b on byte %02h",
						out_ch.last_of_run, want.last, want.data));
				if (out_ch.malformed !== want.bad)
					report_mismatch($sformatf("malformed %b, expected %b on byte %02h",
						out_ch.malformed, want.bad, want.data));
			end
		end
	end

	// queue a unit given in logical order; the current byte order is applied
	task automatic push_unit(input logic [15:0] unit, input logic eoi);
		units_to_send.push_back('{swap_cfg ? {unit[7:0], unit[15:8]} : unit, eoi});
		units_outstanding++;
	endtask

	task automatic push_raw(input logic [15:0] unit, input logic eoi);
		units_to_send.push_back('{unit, eoi});
		units_outstanding++;
	endtask

	task automatic write_swap(input logic v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		swap_cfg = v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// hold until every unit is taken and every byte has come, then let a
	// possibly held surrogate settle
	task automatic wait_idle();
		do
			@(negedge clk);
		while (units_outstanding != 0 || expected_bytes.size() != 0);
		repeat (8) @(negedge clk);
	endtask

	function automatic logic rand_eoi();
		return ($urandom_range(0, 15) == 0);
	endfunction

	task automatic queue_random(input int n);
		int          left;
		logic [15:0] u;
		left = n;
		while (left > 0) begin
			case ($urandom_range(0, 15))
				0, 1, 2: push_unit(16'($urandom_range(0, 16'h7f)), rand_eoi());
				3, 4: push_unit(16'($urandom_range(16'h80, 16'h7ff)), rand_eoi());
				5, 6: begin
					u = $urandom_range(0, 1) ? 16'($urandom_range(16'h800, 16'hd7ff))
						: 16'($urandom_range(16'he000, 16'hffff));
					push_unit(u, rand_eoi());
				end
				7, 8, 9, 10: begin
					push_unit(HighFirst | 16'($urandom_range(0, 16'h3ff)), 1'b0);
					push_unit(LowFirst | 16'($urandom_range(0, 16'h3ff)), rand_eoi());
					left--;
				end
				11: begin
					// possibly broken pair: a held high followed by any unit
					push_unit(HighFirst | 16'($urandom_range(0, 16'h3ff)), 1'b0);
					push_unit(16'($urandom_range(0, 16'hffff)), rand_eoi());
					left--;
				end
				12: push_unit(LowFirst | 16'($urandom_range(0, 16'h3ff)), rand_eoi());
				13: push_unit(HighFirst | 16'($urandom_range(0, 16'h3ff)), 1'b1);
				default: push_raw(16'($urandom_range(0, 16'hffff)),
					1'($urandom_range(0, 1)));
			endcase
			left--;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.code_unit = '0;
		in_ch.end_of_input = 1'b0;
		out_ch.ready = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		write_swap(1'b0);
		// encoding length boundaries
		push_unit(16'h0000, 1'b0);
		push_unit(16'h007f, 1'b0);
		push_unit(16'h0080, 1'b0);
		push_unit(16'h07ff, 1'b0);
		push_unit(16'h0800, 1'b0);
		push_unit(16'hd7ff, 1'b0);
		push_unit(16'he000, 1'b0);
		push_unit(16'hffff, 1'b0);
		// lowest and highest surrogate pairs
		push_unit(16'hd800, 1'b0);
		push_unit(16'hdc00, 1'b0);
		push_unit(16'hdbff, 1'b0);
		push_unit(16'hdfff, 1'b1);
		// lone low surrogates
		push_unit(16'hdc00, 1'b0);
		push_unit(16'hdfff, 1'b0);
		// held high then an ordinary unit
		push_unit(16'hd800, 1'b0);
		push_unit(16'h0041, 1'b0);
		// held high then a high with end of input: two replacements
		push_unit(16'hdbff, 1'b0);
		push_unit(16'hd800, 1'b1);
		// high with end of input alone
		push_unit(16'hdabc, 1'b1);
		// held high then a three-byte unit: six bytes
		push_unit(16'hd800, 1'b0);
		push_unit(16'hffff, 1'b0);
		// end of input on an ordinary unit
		push_unit(16'h1234, 1'b1);
		wait_idle();

		write_swap(1'b1);
		push_raw(16'h00d8, 1'b0);
		push_raw(16'h00dc, 1'b0);
		push_raw(16'h3412, 1'b0);
		push_raw(16'h00d8, 1'b1);
		wait_idle();

		for (int phase = 0; phase < 6; phase++) begin
			write_swap(phase[0]);
			queue_random(75);
			wait_idle();
		end

		if (mismatches == 0) begin
			$display("tb_utf16_to_utf8_transcoder_top passed");
		end else begin
			$display("tb_utf16_to_utf8_transcoder_top failed");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/u16u8_pkg.sv
hw/rtl/u16u8_if.sv
hw/rtl/u16u8_front.sv
hw/rtl/u16u8_queue.sv
hw/rtl/u16u8_back.sv
hw/rtl/utf16_to_utf8_transcoder_top.sv
tb/tb_utf16_to_utf8_transcoder_top.sv
